>>> rtl/murmur_hash64a_assert.svh
// Assertion macros used by the checker of the hash block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef MURMUR_HASH64A_ASSERT_SVH
`define MURMUR_HASH64A_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MH_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MH_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mur64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mur64_pkg: constants and shared types of the 64-bit Murmur hash block
// Holds the mixing multiplier, the shift amount, the seed reset value and
// the step codes of the multiply sequencer.
// ----------------------------------------------------------------------------
package mur64_pkg;

    localparam logic [63:0] MIX_MUL    = 64'hc6a4_a793_5bd1_e995;
    localparam int          MIX_SHIFT  = 47;
    localparam logic [63:0] SEED_RESET = 64'd19780211;

    // What the sequencer does with the product once a multiply completes.
    typedef enum logic [2:0] {
        PH_LEN,   // length times multiplier, starts the running hash
        PH_K1,    // first multiply of a full word
        PH_K2,    // second multiply of a full word
        PH_H,     // multiply of the running hash
        PH_FIN    // multiply inside the finalizer
    } phase_t;

endpackage
`default_nettype wire

>>> rtl/murmur_hash64a.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// murmur_hash64a: streaming 64-bit MurmurHash64A
// Hashes a byte message delivered as little-endian 64-bit words and emits
// one 64-bit hash per message, using a single shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// The block takes one word per transfer on the data channel and works on it
// alone, holding data_stall high until the word is fully folded in. Every
// 64-bit multiply by the mixing constant is built from three 32x32 partial
// products that pass one after the other through the one shared multiplier.
// A word needs one multiply if it is the first word of a message (length
// times the constant), three for a full word, one for a tail of 1 to 7
// bytes, none for zero bytes, and one more if it is the last word
// (finalizer), whose hash is then loaded into the output register. The
// result sits in that output register, so a new word may be taken while
// the previous hash still waits under hash_stall; only a second finished
// hash waits for it. The seed register is written over its own channel,
// which is always ready, and must only be written while no message is
// being hashed.
// ----------------------------------------------------------------------------
module murmur_hash64a (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // data channel
    input  wire logic        data_valid,
    output logic             data_stall,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  valid_bytes,
    input  wire logic        first_word,
    input  wire logic        last_word,
    input  wire logic [63:0] message_length,
    // hash channel
    output logic             hash_valid,
    input  wire logic        hash_stall,
    output logic [63:0]      hash_value,
    // seed register write channel
    input  wire logic        seed_valid,
    output logic             seed_ready,
    input  wire logic [63:0] hash_seed
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WORD,
        ST_MUL,
        ST_FIN,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    mur64_pkg::phase_t  phase_reg, phase_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [63:0]        hash_reg, hash_next;
    logic [63:0]        seed_reg, seed_next;
    logic [63:0]        out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    // Item payload and multiplier datapath; no reset needed.
    logic [63:0]        word_reg, word_next;
    logic               full_reg, full_next;
    logic               tail_reg, tail_next;
    logic               first_reg, first_next;
    logic               last_reg, last_next;
    logic [63:0]        len_reg, len_next;
    logic [63:0]        op_reg, op_next;
    logic [63:0]        prod_reg, prod_next;
    logic [63:0]        acc_reg, acc_next;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_res;
    logic [63:0]        byte_mask;
    logic [63:0]        fin_pre;

    assign data_stall = (state_reg != ST_IDLE);
    assign seed_ready = 1'b1;
    assign hash_valid = out_valid_reg;
    assign hash_value = out_reg;

    // Partial products: lo*lo, then hi*lo and lo*hi shifted up by 32 bits.
    // The hi*hi product falls entirely above bit 63 and is never formed.
    assign mul_a     = (cnt_reg == 2'd1) ? op_reg[63:32] : op_reg[31:0];
    assign mul_b     = (cnt_reg == 2'd2) ? mur64_pkg::MIX_MUL[63:32]
                                         : mur64_pkg::MIX_MUL[31:0];
    assign prod_next = {32'd0, mul_a} * {32'd0, mul_b};
    assign mul_res   = acc_reg + {prod_reg[31:0], 32'd0};
    assign fin_pre   = hash_reg ^ (hash_reg >> mur64_pkg::MIX_SHIFT);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_mask[i*8 +: 8] = (4'(i) < valid_bytes) ? 8'hFF : 8'h00;
        end
    end

    always_comb
    begin
        case (cnt_reg)
            2'd1:    acc_next = prod_reg;
            2'd2:    acc_next = mul_res;
            default: acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        hash_next      = hash_reg;
        seed_next      = seed_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        full_next      = full_reg;
        tail_next      = tail_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        len_next       = len_reg;
        op_next        = op_reg;

        if (seed_valid)
        begin
            seed_next = hash_seed;
        end

        if (out_valid_reg && !hash_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (data_valid)
                begin
                    // Counts above eight are treated as a full word.
                    word_next  = data_word & byte_mask;
                    full_next  = (valid_bytes >= 4'd8);
                    tail_next  = (valid_bytes != 4'd0) && (valid_bytes < 4'd8);
                    first_next = first_word;
                    last_next  = last_word;
                    len_next   = message_length;
                    state_next = ST_START;
                end
            end

            ST_START:
            begin
                if (first_reg)
                begin
                    op_next    = len_reg;
                    phase_next = mur64_pkg::PH_LEN;
                    cnt_next   = 2'd0;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_WORD;
                end
            end

            ST_WORD:
            begin
                if (full_reg)
                begin
                    op_next    = word_reg;
                    phase_next = mur64_pkg::PH_K1;
                    cnt_next   = 2'd0;
                    state_next = ST_MUL;
                end
                else if (tail_reg)
                begin
                    hash_next  = hash_reg ^ word_reg;
                    op_next    = hash_reg ^ word_reg;
                    phase_next = mur64_pkg::PH_H;
                    cnt_next   = 2'd0;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (last_reg)
                begin
                    op_next    = fin_pre;
                    phase_next = mur64_pkg::PH_FIN;
                    cnt_next   = 2'd0;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_MUL:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    cnt_next = 2'd0;
                    case (phase_reg)
                        mur64_pkg::PH_LEN:
                        begin
                            hash_next  = seed_reg ^ mul_res;
                            state_next = ST_WORD;
                        end
                        mur64_pkg::PH_K1:
                        begin
                            op_next    = mul_res ^ (mul_res >> mur64_pkg::MIX_SHIFT);
                            phase_next = mur64_pkg::PH_K2;
                        end
                        mur64_pkg::PH_K2:
                        begin
                            op_next    = hash_reg ^ mul_res;
                            phase_next = mur64_pkg::PH_H;
                        end
                        mur64_pkg::PH_H:
                        begin
                            hash_next  = mul_res;
                            state_next = ST_FIN;
                        end
                        mur64_pkg::PH_FIN:
                        begin
                            hash_next  = mul_res ^ (mul_res >> mur64_pkg::MIX_SHIFT);
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_EMIT:
            begin
                // Wait until the output register is free or being drained.
                if (!out_valid_reg || !hash_stall)
                begin
                    out_next       = hash_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= mur64_pkg::PH_LEN;
            cnt_reg       <= 2'd0;
            hash_reg      <= 64'd0;
            seed_reg      <= mur64_pkg::SEED_RESET;
            out_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            hash_reg      <= hash_next;
            seed_reg      <= seed_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        full_reg  <= full_next;
        tail_reg  <= tail_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        len_reg   <= len_next;
        op_reg    <= op_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
    end

endmodule
`default_nettype wire

>>> rtl/mur64_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mur64_check: port-level checker for the hash block
// Watches the data and hash channels and flags sequencing errors.
// ----------------------------------------------------------------------------
`include "murmur_hash64a_assert.svh"

module mur64_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        data_valid,
    input wire logic        data_stall,
    input wire logic        last_word,
    input wire logic        hash_valid,
    input wire logic        hash_stall,
    input wire logic [63:0] hash_value
);

    logic data_xfer;

    assign data_xfer = data_valid && !data_stall;

    // A held hash keeps its value until it is taken.
    `MH_ASSERT_NEXT(a_hash_hold, hash_valid && hash_stall, hash_valid && $stable(hash_value), "hash changed while stalled")

    // Each word keeps the block busy in the cycle after its transfer.
    `MH_ASSERT_NEXT(a_busy_after_xfer, data_xfer, data_stall, "block ready right after a transfer")

    // A new hash only appears at the end of work on a word.
    `MH_ASSERT_NOW(a_hash_from_work, $rose(hash_valid), $past(data_stall), "hash appeared while idle")

    // A word that is not the last one never yields a hash in the next cycle.
    `MH_ASSERT_NEXT(a_no_early_hash, data_xfer && !last_word, !$rose(hash_valid), "hash right after middle word")

endmodule

bind murmur_hash64a mur64_check u_mur64_check (.*);
`default_nettype wire
